[rtl/core/lcdns_pkg.sv]
// ----------------------------------------------------------------------------
// lcdns_pkg: shared types and constants for the LCD nibble sequencer
// Job encoding between the request front end and the pin-state back end,
// request codes, register indexes and the fixed display timing values.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  // Settling time after each enable edge, in microseconds.
  localparam int SETTLE_US = 100;

  // Request codes.
  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_CURSOR = 2'd2;
  localparam logic [1:0] REQ_INIT   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FUNCTION_SET = 2'd0;
  localparam logic [1:0] REG_ENTRY_MODE   = 2'd1;
  localparam logic [1:0] REG_DISPLAY_ON   = 2'd2;
  localparam logic [1:0] REG_CLEAR        = 2'd3;

  // Job kinds: a single wait state, one nibble, or a whole byte.
  localparam logic [1:0] JOB_WAIT   = 2'd0;
  localparam logic [1:0] JOB_NIBBLE = 2'd1;
  localparam logic [1:0] JOB_BYTE   = 2'd2;

  // Extra wait that follows the final nibble of a job.
  localparam logic [2:0] EXTRA_NONE   = 3'd0;
  localparam logic [2:0] EXTRA_POWER  = 3'd1;
  localparam logic [2:0] EXTRA_LONG   = 3'd2;
  localparam logic [2:0] EXTRA_SHORT  = 3'd3;
  localparam logic [2:0] EXTRA_CLEAR  = 3'd4;

  // Hold times of the setup and strobe phases and of the opening wait.
  localparam logic [13:0] HOLD_SETUP     = 14'(SETTLE_US + 1);
  localparam logic [13:0] HOLD_STROBE    = 14'd1;
  localparam logic [13:0] HOLD_INIT_WAIT = 14'd5000;

  // Queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       rs;
    logic [2:0] extra;
    logic       last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Hold time of the release phase, including any extra wait.
  function automatic logic [13:0] release_hold(input logic [2:0] extra);
    logic [13:0] hold;
    case (extra)
      EXTRA_POWER: hold = 14'(SETTLE_US + 5000);
      EXTRA_LONG:  hold = 14'(SETTLE_US + 10000);
      EXTRA_SHORT: hold = 14'(SETTLE_US + 100);
      EXTRA_CLEAR: hold = 14'(SETTLE_US + 2000);
      default:     hold = 14'(SETTLE_US);
    endcase
    return hold;
  endfunction

endpackage

[rtl/core/char_lcd_nibble_sequencer_core.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core: 4-bit character LCD pin sequencer
// Turns command, data, cursor and init requests into timed pin states.
// ----------------------------------------------------------------------------
// Each accepted request becomes a list of pin states (nibble, RS, EN, hold
// time in microseconds), with last set on the final state. Pin states leave
// the output register one per cycle while out_ready is high, so a command,
// data or cursor request becomes six pin states and an init request 37;
// they are made by the back-end phase sequencer, which emits one state per
// cycle. The front end queues up to four jobs ahead of it, so further
// requests are taken while earlier ones are still being sent. An init
// request is expanded into nine jobs, one per cycle as queue space allows,
// and no new request is taken until that expansion is done. Configuration
// writes take effect at once and are meant for times when the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  value,
  input  logic        row,
  input  logic [5:0]  col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  pin_nibble,
  output logic        pin_rs,
  output logic        pin_en,
  output logic [13:0] hold_us,
  output logic        last
);

  lcdns_pkg::job_t      push_job;
  lcdns_pkg::job_t      head_job;
  lcdns_pkg::q_status_t q_stat;
  logic                 push;
  logic                 pop;

  // Request intake.
  lcdns_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .row       (row),
    .col       (col),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Job queue.
  lcdns_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // Pin-state generation.
  lcdns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pin_nibble (pin_nibble),
    .pin_rs     (pin_rs),
    .pin_en     (pin_en),
    .hold_us    (hold_us),
    .last       (last)
  );

endmodule

[rtl/core/lcdns_front.sv]
// ----------------------------------------------------------------------------
// lcdns_front: request intake and classification
// Holds the init command registers, turns each request into queue jobs and
// expands the power-up init into its sequence of nine jobs.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [7:0]          value,
  input  logic                row,
  input  logic [5:0]          col,
  input  lcdns_pkg::q_status_t q_stat,
  output logic                push,
  output lcdns_pkg::job_t     push_job
);

  // Init sequence steps after the opening wait, which goes out on acceptance.
  localparam logic [3:0] STEP_IDLE   = 4'd0;
  localparam logic [3:0] STEP_SYNC1  = 4'd1;
  localparam logic [3:0] STEP_SYNC2  = 4'd2;
  localparam logic [3:0] STEP_SYNC3  = 4'd3;
  localparam logic [3:0] STEP_FOUR   = 4'd4;
  localparam logic [3:0] STEP_FUNC   = 4'd5;
  localparam logic [3:0] STEP_ENTRY  = 4'd6;
  localparam logic [3:0] STEP_DISP   = 4'd7;
  localparam logic [3:0] STEP_CLEAR  = 4'd8;

  logic [7:0] function_set_code;
  logic [7:0] entry_mode_code;
  logic [7:0] display_on_code;
  logic [7:0] clear_code;
  logic [3:0] init_step;
  logic [3:0] init_step_next;
  logic       accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      function_set_code <= 8'd40;
      entry_mode_code   <= 8'd6;
      display_on_code   <= 8'd12;
      clear_code        <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdns_pkg::REG_FUNCTION_SET: function_set_code <= cfg_data;
        lcdns_pkg::REG_ENTRY_MODE:   entry_mode_code   <= cfg_data;
        lcdns_pkg::REG_DISPLAY_ON:   display_on_code   <= cfg_data;
        default:                     clear_code        <= cfg_data;
      endcase
    end
  end

  // New requests are taken only while no init expansion is pending.
  assign in_ready = (init_step == STEP_IDLE) && !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Job selection for the queue.
  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (init_step != STEP_IDLE) begin
      push           = !q_stat.full;
      push_job.kind  = lcdns_pkg::JOB_BYTE;
      push_job.extra = lcdns_pkg::EXTRA_NONE;
      case (init_step)
        STEP_SYNC1: begin
          push_job.kind  = lcdns_pkg::JOB_NIBBLE;
          push_job.data  = 8'h03;
          push_job.extra = lcdns_pkg::EXTRA_POWER;
        end
        STEP_SYNC2: begin
          push_job.kind  = lcdns_pkg::JOB_NIBBLE;
          push_job.data  = 8'h03;
          push_job.extra = lcdns_pkg::EXTRA_LONG;
        end
        STEP_SYNC3: begin
          push_job.kind  = lcdns_pkg::JOB_NIBBLE;
          push_job.data  = 8'h03;
          push_job.extra = lcdns_pkg::EXTRA_SHORT;
        end
        STEP_FOUR: begin
          push_job.kind  = lcdns_pkg::JOB_NIBBLE;
          push_job.data  = 8'h02;
          push_job.extra = lcdns_pkg::EXTRA_SHORT;
        end
        STEP_FUNC:  push_job.data = function_set_code;
        STEP_ENTRY: push_job.data = entry_mode_code;
        STEP_DISP:  push_job.data = display_on_code;
        default: begin
          push_job.data  = clear_code;
          push_job.extra = lcdns_pkg::EXTRA_CLEAR;
          push_job.last  = 1'b1;
        end
      endcase
    end else if (accept) begin
      push          = 1'b1;
      push_job.kind = lcdns_pkg::JOB_BYTE;
      push_job.last = 1'b1;
      case (req_type)
        lcdns_pkg::REQ_CMD:    push_job.data = value;
        lcdns_pkg::REQ_DATA: begin
          push_job.data = value;
          push_job.rs   = 1'b1;
        end
        lcdns_pkg::REQ_CURSOR: push_job.data = {1'b1, row, col};
        default: begin
          // Init opens with the power-up wait; the rest follows step by step.
          push_job.kind = lcdns_pkg::JOB_WAIT;
          push_job.last = 1'b0;
        end
      endcase
    end
  end

  // Init step counter.
  always_comb begin
    init_step_next = init_step;
    if (init_step != STEP_IDLE) begin
      if (!q_stat.full) begin
        init_step_next = (init_step == STEP_CLEAR) ? STEP_IDLE : init_step + 4'd1;
      end
    end else if (accept && (req_type == lcdns_pkg::REQ_INIT)) begin
      init_step_next = STEP_SYNC1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_step <= STEP_IDLE;
    end else begin
      init_step <= init_step_next;
    end
  end

endmodule

[rtl/core/lcdns_queue.sv]
// ----------------------------------------------------------------------------
// lcdns_queue: job queue between front end and back end
// A small first-in first-out store of jobs so that intake and pin-state
// generation stall independently.
// ----------------------------------------------------------------------------
module lcdns_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lcdns_pkg::job_t      push_job,
  input  logic                 pop,
  output lcdns_pkg::job_t      head_job,
  output lcdns_pkg::q_status_t q_stat
);

  localparam int PW = lcdns_pkg::QUEUE_PTR_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(lcdns_pkg::QUEUE_DEPTH - 1);

  lcdns_pkg::job_t slots [lcdns_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic [PW:0]     count_next;

  assign q_stat.full  = (count == (PW+1)'(lcdns_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head_job     = slots[rd_ptr];

  // Occupancy follows the push and pop strobes.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + (PW+1)'(1);
    end else if (pop && !push) begin
      count_next = count - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("job popped from an empty queue");
`endif

endmodule

[rtl/core/lcdns_back.sv]
// ----------------------------------------------------------------------------
// lcdns_back: pin-state generator
// Walks the head job through its enable phases into an output register,
// one pin state per cycle while that register is free or draining.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lcdns_pkg::job_t      head_job,
  input  lcdns_pkg::q_status_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           pin_nibble,
  output logic                 pin_rs,
  output logic                 pin_en,
  output logic [13:0]          hold_us,
  output logic                 last
);

  localparam logic [1:0] PH_SETUP   = 2'd0;
  localparam logic [1:0] PH_STROBE  = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;

  logic [1:0]  phase;
  logic        half;
  logic        gen;
  logic        step_done;
  logic        final_nib;
  logic [3:0]  nib_next;
  logic        en_next;
  logic [13:0] hold_next;

  // Current pin state of the head job.
  always_comb begin
    final_nib = (head_job.kind == lcdns_pkg::JOB_NIBBLE) || half;
    nib_next  = ((head_job.kind == lcdns_pkg::JOB_BYTE) && !half) ?
                head_job.data[7:4] : head_job.data[3:0];
    case (phase)
      PH_SETUP: begin
        en_next   = 1'b0;
        hold_next = lcdns_pkg::HOLD_SETUP;
      end
      PH_STROBE: begin
        en_next   = 1'b1;
        hold_next = lcdns_pkg::HOLD_STROBE;
      end
      default: begin
        en_next   = 1'b0;
        hold_next = lcdns_pkg::release_hold(final_nib ? head_job.extra :
                                            lcdns_pkg::EXTRA_NONE);
      end
    endcase
    step_done = (phase == PH_RELEASE) && final_nib;
    if (head_job.kind == lcdns_pkg::JOB_WAIT) begin
      nib_next  = 4'h0;
      en_next   = 1'b0;
      hold_next = lcdns_pkg::HOLD_INIT_WAIT;
      step_done = 1'b1;
    end
  end

  // A state is produced whenever a job is queued and the output register is free or draining.
  assign gen = !q_stat.empty && (!out_valid || out_ready);
  assign pop = gen && step_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SETUP;
      half      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (gen) begin
        out_valid <= 1'b1;
        if (step_done) begin
          phase <= PH_SETUP;
          half  <= 1'b0;
        end else if (phase == PH_RELEASE) begin
          phase <= PH_SETUP;
          half  <= 1'b1;
        end else begin
          phase <= phase + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (gen) begin
      pin_nibble <= nib_next;
      pin_rs     <= head_job.rs;
      pin_en     <= en_next;
      hold_us    <= hold_next;
      last       <= head_job.last && step_done;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("enable phase counter left its range");

  a_strobe_short: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pin_en) |-> (hold_us == lcdns_pkg::HOLD_STROBE && !last))
    else $error("enable strobe state with wrong hold or end mark");
`endif

endmodule

[tb/sv/lcd_pin_sequence_checker.sv]
// ----------------------------------------------------------------------------
// lcd_pin_sequence_checker: pin-state predictor and scoreboard
// Watches the configuration port and both transfer channels of the LCD
// nibble sequencer. It expands every accepted request into the pin states
// that it should cause and checks the emitted states against them in order.
// ----------------------------------------------------------------------------
module lcd_pin_sequence_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  value,
  input  logic        row,
  input  logic [5:0]  col,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  pin_nibble,
  input  logic        pin_rs,
  input  logic        pin_en,
  input  logic [13:0] hold_us,
  input  logic        last,
  output int          mismatches,
  output int          pending
);

  // Power-on values of the init command bytes.
  localparam logic [7:0] FUNCTION_SET_RESET = 8'd40;
  localparam logic [7:0] ENTRY_MODE_RESET   = 8'd6;
  localparam logic [7:0] DISPLAY_ON_RESET   = 8'd12;
  localparam logic [7:0] CLEAR_RESET        = 8'd1;

  // Init timing in microseconds.
  localparam int OPENING_WAIT_US = 5000;
  localparam int POWER_EXTRA_US  = 5000;
  localparam int LONG_EXTRA_US   = 10000;
  localparam int SHORT_EXTRA_US  = 100;
  localparam int CLEAR_EXTRA_US  = 2000;

  // Cursor base addresses of the two rows.
  localparam logic [7:0] ROW0_BASE = 8'd128;
  localparam logic [7:0] ROW1_BASE = 8'd192;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic        en;
    logic [13:0] hold;
    logic        last;
  } pin_state_t;

  pin_state_t expected_pins[$];
  logic [7:0] function_set_code;
  logic [7:0] entry_mode_code;
  logic [7:0] display_on_code;
  logic [7:0] clear_code;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic void push_state(logic [3:0] nib, logic rs, logic en,
                                     logic [13:0] hold, logic fin);
    pin_state_t s;
    s.nibble = nib;
    s.rs = rs;
    s.en = en;
    s.hold = hold;
    s.last = fin;
    expected_pins.push_back(s);
  endfunction

  // One nibble: setup, strobe high, release with any extra wait.
  function automatic void push_nibble(logic [3:0] nib, logic rs, int extra_us,
                                      logic fin);
    push_state(nib, rs, 1'b0, 14'(lcdns_pkg::SETTLE_US + 1), 1'b0);
    push_state(nib, rs, 1'b1, 14'd1, 1'b0);
    push_state(nib, rs, 1'b0, 14'(lcdns_pkg::SETTLE_US + extra_us), fin);
  endfunction

  // A byte goes out high nibble first; the extra wait follows the low one.
  function automatic void push_byte(logic [7:0] b, logic rs, int extra_us,
                                    logic fin);
    push_nibble(b[7:4], rs, 0, 1'b0);
    push_nibble(b[3:0], rs, extra_us, fin);
  endfunction

  function automatic void expand_request(logic [1:0] kind, logic [7:0] val,
                                         logic r, logic [5:0] c);
    logic [7:0] addr;
    addr = (r ? ROW1_BASE : ROW0_BASE) + {2'b00, c};
    case (kind)
      lcdns_pkg::REQ_CMD:    push_byte(val, 1'b0, 0, 1'b1);
      lcdns_pkg::REQ_DATA:   push_byte(val, 1'b1, 0, 1'b1);
      lcdns_pkg::REQ_CURSOR: push_byte(addr, 1'b0, 0, 1'b1);
      default: begin
        // Power-up wait, the 8-bit wake-up nibbles, then the setup commands.
        push_state(4'd0, 1'b0, 1'b0, 14'(OPENING_WAIT_US), 1'b0);
        push_nibble(4'd3, 1'b0, POWER_EXTRA_US, 1'b0);
        push_nibble(4'd3, 1'b0, LONG_EXTRA_US, 1'b0);
        push_nibble(4'd3, 1'b0, SHORT_EXTRA_US, 1'b0);
        push_nibble(4'd2, 1'b0, SHORT_EXTRA_US, 1'b0);
        push_byte(function_set_code, 1'b0, 0, 1'b0);
        push_byte(entry_mode_code, 1'b0, 0, 1'b0);
        push_byte(display_on_code, 1'b0, 0, 1'b0);
        push_byte(clear_code, 1'b0, CLEAR_EXTRA_US, 1'b1);
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Track register writes, expand accepted requests and score pin states.
  always @(posedge clk) begin
    pin_state_t want;
    if (rst) begin
      function_set_code = FUNCTION_SET_RESET;
      entry_mode_code = ENTRY_MODE_RESET;
      display_on_code = DISPLAY_ON_RESET;
      clear_code = CLEAR_RESET;
      expected_pins.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lcdns_pkg::REG_FUNCTION_SET: function_set_code = cfg_data;
          lcdns_pkg::REG_ENTRY_MODE:   entry_mode_code = cfg_data;
          lcdns_pkg::REG_DISPLAY_ON:   display_on_code = cfg_data;
          lcdns_pkg::REG_CLEAR:        clear_code = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expand_request(req_type, value, row, col);
      end
      if (out_valid && out_ready) begin
        if (expected_pins.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pin state transfer, expected none, got nibble %0d",
                   $time, pin_nibble, " rs %0d en %0d hold %0d last %0d",
                   pin_rs, pin_en, hold_us, last);
        end else begin
          want = expected_pins.pop_front();
          check_field("pin_nibble", 32'(want.nibble), 32'(pin_nibble));
          check_field("pin_rs", 32'(want.rs), 32'(pin_rs));
          check_field("pin_en", 32'(want.en), 32'(pin_en));
          check_field("hold_us", 32'(want.hold), 32'(hold_us));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
    end
    pending = expected_pins.size();
  end

endmodule

[tb/sv/tb_char_lcd_nibble_sequencer_core.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer_core: testbench of the LCD nibble sequencer
// Sends directed and random command, data, cursor and init requests under
// several register settings and idle patterns, lets the pin-state checker
// score the results, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_core;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 50;
  localparam int PHASE_ITEMS = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = lcdns_pkg::REG_FUNCTION_SET;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic [1:0]  req_type = lcdns_pkg::REQ_CMD;
  logic [7:0]  value = 8'd0;
  logic        row = 1'b0;
  logic [5:0]  col = 6'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  pin_nibble;
  logic        pin_rs;
  logic        pin_en;
  logic [13:0] hold_us;
  logic        last;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  char_lcd_nibble_sequencer_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .value(value), .row(row), .col(col),
    .out_valid(out_valid), .out_ready(out_ready),
    .pin_nibble(pin_nibble), .pin_rs(pin_rs), .pin_en(pin_en),
    .hold_us(hold_us), .last(last)
  );

  lcd_pin_sequence_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .value(value), .row(row), .col(col),
    .out_valid(out_valid), .out_ready(out_ready),
    .pin_nibble(pin_nibble), .pin_rs(pin_rs), .pin_en(pin_en),
    .hold_us(hold_us), .last(last),
    .mismatches(mismatches), .pending(pending)
  );

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_char_lcd_nibble_sequencer_core failed");
      $finish;
    end
  end

  // Write all four init command bytes, one register per cycle.
  task automatic write_init_codes(logic [7:0] fs, logic [7:0] em, logic [7:0] don,
                                  logic [7:0] clr);
    logic [7:0] codes [4];
    codes[lcdns_pkg::REG_FUNCTION_SET] = fs;
    codes[lcdns_pkg::REG_ENTRY_MODE] = em;
    codes[lcdns_pkg::REG_DISPLAY_ON] = don;
    codes[lcdns_pkg::REG_CLEAR] = clr;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= codes[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Extremes half of the time, any byte otherwise.
  function automatic logic [7:0] pick_code();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one request and hold it until the transfer happens.
  task automatic send_request(logic [1:0] kind, logic [7:0] v, logic r, logic [5:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    value <= v;
    row <= r;
    col <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_request();
    logic [1:0] kind;
    if ($urandom_range(99) < 10) begin
      kind = lcdns_pkg::REQ_INIT;
    end else begin
      case ($urandom_range(2))
        0:       kind = lcdns_pkg::REQ_CMD;
        1:       kind = lcdns_pkg::REQ_DATA;
        default: kind = lcdns_pkg::REQ_CURSOR;
      endcase
    end
    send_request(kind, 8'($urandom), 1'($urandom), 6'($urandom));
  endtask

  // Stop offering and wait until every expected pin state has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests with reset register values; unused fields are set
    // to show that they are ignored.
    send_request(lcdns_pkg::REQ_CMD, 8'h00, 1'b0, 6'd0);
    send_request(lcdns_pkg::REQ_CMD, 8'hff, 1'b1, 6'd63);
    send_request(lcdns_pkg::REQ_DATA, 8'h00, 1'b0, 6'd0);
    send_request(lcdns_pkg::REQ_DATA, 8'hff, 1'b1, 6'd63);
    send_request(lcdns_pkg::REQ_DATA, 8'ha5, 1'b0, 6'd21);
    send_request(lcdns_pkg::REQ_CMD, 8'h5a, 1'b1, 6'd42);
    send_request(lcdns_pkg::REQ_CURSOR, 8'hff, 1'b0, 6'd0);
    send_request(lcdns_pkg::REQ_CURSOR, 8'h00, 1'b0, 6'd63);
    send_request(lcdns_pkg::REQ_CURSOR, 8'hff, 1'b1, 6'd0);
    send_request(lcdns_pkg::REQ_CURSOR, 8'h00, 1'b1, 6'd63);
    send_request(lcdns_pkg::REQ_INIT, 8'hff, 1'b1, 6'd63);
    send_request(lcdns_pkg::REQ_DATA, 8'h3c, 1'b0, 6'd0);
    wait_idle();

    // Init with the register extremes.
    write_init_codes(8'h00, 8'h00, 8'h00, 8'h00);
    send_request(lcdns_pkg::REQ_INIT, 8'h00, 1'b0, 6'd0);
    wait_idle();
    write_init_codes(8'hff, 8'hff, 8'hff, 8'hff);
    send_request(lcdns_pkg::REQ_INIT, 8'h00, 1'b0, 6'd0);
    send_request(lcdns_pkg::REQ_CMD, 8'h80, 1'b0, 6'd0);
    wait_idle();

    // Random phases: no idling, sender gaps, receiver stalls, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 48; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      write_init_codes(pick_code(), pick_code(), pick_code(), pick_code());
      repeat (PHASE_ITEMS) send_random_request();
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_char_lcd_nibble_sequencer_core passed");
    end else begin
      $display("tb_char_lcd_nibble_sequencer_core failed");
    end
    $finish;
  end

endmodule

[char_lcd_nibble_sequencer_core.f]
rtl/core/lcdns_pkg.sv
rtl/core/lcdns_front.sv
rtl/core/lcdns_queue.sv
rtl/core/lcdns_back.sv
rtl/core/char_lcd_nibble_sequencer_core.sv
tb/sv/lcd_pin_sequence_checker.sv
tb/sv/tb_char_lcd_nibble_sequencer_core.sv
